### src/pc_pkg.sv
// Shared widths and result type for the polygon centroid block.
package pc_pkg;

  // Coordinate and arithmetic widths.
  localparam int unsigned CoordW  = 16;
  localparam int unsigned SumW    = CoordW + 1;      // px + qx
  localparam int unsigned CrossW  = 2 * CoordW + 1;  // px*qy - qx*py
  localparam int unsigned ProdW   = SumW + CrossW;   // (px + qx) * cross
  localparam int unsigned AreaW   = 44;
  localparam int unsigned MomW    = 61;
  localparam int unsigned DenW    = AreaW + 2;       // 3 * area
  localparam int unsigned DivCntW = $clog2(MomW);

  // Saturation limits of a centroid coordinate.
  localparam logic [CoordW-1:0] CoordMax = {1'b0, {(CoordW-1){1'b1}}};
  localparam logic [CoordW-1:0] CoordMin = {1'b1, {(CoordW-1){1'b0}}};

  // One result transaction.
  typedef struct packed {
    logic [CoordW-1:0] centroid_y;
    logic [CoordW-1:0] centroid_x;
    logic              overflow;
    logic              degenerate;
  } result_t;

endpackage

### src/polygon_centroid.sv
// Streaming polygon centroid by the shoelace method, on one shared multiplier and divider.

// Vertices arrive one per input transaction as signed 16-bit x and y, with
// tlast on the final vertex. Each edge adds its cross product to the doubled
// area and its weighted cross products to the two first moments, all through a
// single registered 17x33 multiplier, so an ordinary vertex passes through
// StMul1, StMul2, StCross, StMul3, StMul4 and StAcc (tready is high only in
// StIdle). The final vertex also closes the ring back to the first vertex and
// then divides each moment by three times the doubled area with one restoring
// divider, one quotient bit per cycle. That vertex keeps tready low until its
// result is loaded; the division is skipped when the area is zero or the vertex
// count overflowed; the load may wait for the output register. The result is
// truncated toward zero and saturated to 16 bits. Zero area gives centroid
// 0,0 with degenerate set; more than MAX_VERTICES vertices gives 0,0 with
// overflow set. A finished result waits in an output register, so the next
// polygon may start while it is still not taken.
module polygon_centroid #(
  parameter int unsigned MAX_VERTICES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Vertex input: tdata = vertex_x[15:0], vertex_y[31:16]; tlast = last_vertex.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  // Result: tdata = centroid_x[15:0], centroid_y[31:16];
  // tuser = degenerate[0], overflow[1].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned CntW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [3:0] {
    StIdle,
    StMul1,
    StMul2,
    StCross,
    StMul3,
    StMul4,
    StAcc,
    StClose,
    StCheck,
    StDenAbs,
    StDivLoad,
    StDiv,
    StDivSat,
    StOut
  } state_e;

  state_e state_q;

  // Polygon state.
  logic signed [pc_pkg::CoordW-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
  logic signed [pc_pkg::AreaW-1:0]  area_q;
  logic signed [pc_pkg::MomW-1:0]   mom_x_q, mom_y_q;
  logic [CntW-1:0]                  count_q;
  logic                             ovf_q;
  logic                             last_q;
  logic                             closing_q;

  // Edge operands and multiplier pipeline.
  logic signed [pc_pkg::CoordW-1:0] px_q, py_q, qx_q, qy_q;
  logic signed [pc_pkg::SumW-1:0]   sx_q, sy_q;
  logic signed [pc_pkg::CrossW-1:0] cross_q;
  logic signed [pc_pkg::ProdW-1:0]  prod_q;
  logic signed [pc_pkg::SumW-1:0]   mul_a;
  logic signed [pc_pkg::CrossW-1:0] mul_b;
  logic signed [pc_pkg::ProdW-1:0]  prod_d;

  // Divider state.
  logic signed [pc_pkg::DenW-1:0]   den3_q;
  logic [pc_pkg::DenW-1:0]          den_q;
  logic                             den_neg_q;
  logic [pc_pkg::DenW-1:0]          rem_q;
  logic [pc_pkg::MomW-1:0]          quo_q;
  logic                             quo_neg_q;
  logic [pc_pkg::DivCntW-1:0]       div_cnt_q;
  logic                             axis_q;
  logic [pc_pkg::DenW:0]            div_shift;
  logic [pc_pkg::DenW+1:0]          div_diff;
  logic                             div_ge;
  logic signed [pc_pkg::MomW-1:0]   mom_sel;
  logic [pc_pkg::CoordW-1:0]        sat_res;
  logic                             quo_big;

  // Result and output register.
  logic [pc_pkg::CoordW-1:0]        cx_q;
  pc_pkg::result_t                  res_q;
  logic                             out_valid_q;
  logic                             load_out;

  logic                             s_accept;
  logic signed [pc_pkg::CoordW-1:0] in_x, in_y;

  assign in_x     = s_axis_tdata[15:0];
  assign in_y     = s_axis_tdata[31:16];
  assign s_axis_tready = (state_q == StIdle);
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A finished result enters the output register once it is free or emptying.
  assign load_out = (state_q == StOut) && (!out_valid_q || m_axis_tready);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {res_q.centroid_y, res_q.centroid_x};
  assign m_axis_tuser  = {res_q.overflow, res_q.degenerate};

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      StMul1: begin
        mul_a = pc_pkg::SumW'(px_q);
        mul_b = pc_pkg::CrossW'(qy_q);
      end
      StMul2: begin
        mul_a = pc_pkg::SumW'(qx_q);
        mul_b = pc_pkg::CrossW'(py_q);
      end
      StMul3: begin
        mul_a = sx_q;
        mul_b = cross_q;
      end
      StMul4: begin
        mul_a = sy_q;
        mul_b = cross_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_d = mul_a * mul_b;
  end

  // One restoring division step and the saturation of the finished quotient.
  always_comb begin
    div_shift = {rem_q, quo_q[pc_pkg::MomW-1]};
    div_diff  = {1'b0, div_shift} - {2'b00, den_q};
    div_ge    = !div_diff[pc_pkg::DenW+1];
    mom_sel   = axis_q ? mom_y_q : mom_x_q;
    quo_big   = |quo_q[pc_pkg::MomW-1:pc_pkg::CoordW];
    if (quo_neg_q) begin
      if (quo_big || (quo_q[pc_pkg::CoordW-1] && (|quo_q[pc_pkg::CoordW-2:0]))) begin
        sat_res = pc_pkg::CoordMin;
      end else begin
        sat_res = -quo_q[pc_pkg::CoordW-1:0];
      end
    end else begin
      if (quo_big || quo_q[pc_pkg::CoordW-1]) begin
        sat_res = pc_pkg::CoordMax;
      end else begin
        sat_res = quo_q[pc_pkg::CoordW-1:0];
      end
    end
  end

  // Sequencer, accumulators, divider and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      first_x_q   <= '0;
      first_y_q   <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      area_q      <= '0;
      mom_x_q     <= '0;
      mom_y_q     <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      last_q      <= 1'b0;
      closing_q   <= 1'b0;
      px_q        <= '0;
      py_q        <= '0;
      qx_q        <= '0;
      qy_q        <= '0;
      sx_q        <= '0;
      sy_q        <= '0;
      cross_q     <= '0;
      prod_q      <= '0;
      den3_q      <= '0;
      den_q       <= '0;
      den_neg_q   <= 1'b0;
      rem_q       <= '0;
      quo_q       <= '0;
      quo_neg_q   <= 1'b0;
      div_cnt_q   <= '0;
      axis_q      <= 1'b0;
      cx_q        <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // The output register fills with a new result or empties when its
      // transaction completes.
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        StIdle: begin
          if (s_accept) begin
            last_q    <= s_axis_tlast;
            closing_q <= 1'b0;
            px_q      <= prev_x_q;
            py_q      <= prev_y_q;
            qx_q      <= in_x;
            qy_q      <= in_y;
            if (count_q >= CntW'(MAX_VERTICES)) begin
              // Vertex dropped.
              ovf_q   <= 1'b1;
              state_q <= s_axis_tlast ? StClose : StIdle;
            end else if (count_q == '0) begin
              first_x_q <= in_x;
              first_y_q <= in_y;
              prev_x_q  <= in_x;
              prev_y_q  <= in_y;
              count_q   <= count_q + 1'b1;
              state_q   <= s_axis_tlast ? StClose : StIdle;
            end else begin
              prev_x_q <= in_x;
              prev_y_q <= in_y;
              count_q  <= count_q + 1'b1;
              state_q  <= StMul1;
            end
          end
        end
        StMul1: begin
          prod_q  <= prod_d;
          sx_q    <= pc_pkg::SumW'(px_q) + pc_pkg::SumW'(qx_q);
          sy_q    <= pc_pkg::SumW'(py_q) + pc_pkg::SumW'(qy_q);
          state_q <= StMul2;
        end
        StMul2: begin
          cross_q <= pc_pkg::CrossW'(prod_q);
          prod_q  <= prod_d;
          state_q <= StCross;
        end
        StCross: begin
          cross_q <= cross_q - pc_pkg::CrossW'(prod_q);
          state_q <= StMul3;
        end
        StMul3: begin
          area_q  <= area_q + pc_pkg::AreaW'(cross_q);
          prod_q  <= prod_d;
          state_q <= StMul4;
        end
        StMul4: begin
          mom_x_q <= mom_x_q + pc_pkg::MomW'(prod_q);
          prod_q  <= prod_d;
          state_q <= StAcc;
        end
        StAcc: begin
          mom_y_q <= mom_y_q + pc_pkg::MomW'(prod_q);
          if (closing_q) begin
            state_q <= StCheck;
          end else if (last_q) begin
            state_q <= StClose;
          end else begin
            state_q <= StIdle;
          end
        end
        StClose: begin
          // Edge from the last kept vertex back to the first one.
          closing_q <= 1'b1;
          px_q      <= prev_x_q;
          py_q      <= prev_y_q;
          qx_q      <= first_x_q;
          qy_q      <= first_y_q;
          state_q   <= StMul1;
        end
        StCheck: begin
          den3_q <= pc_pkg::DenW'(area_q) + (pc_pkg::DenW'(area_q) <<< 1);
          if (ovf_q) begin
            cx_q    <= '0;
            state_q <= StOut;
          end else if (area_q == '0) begin
            cx_q    <= '0;
            state_q <= StOut;
          end else begin
            state_q <= StDenAbs;
          end
        end
        StDenAbs: begin
          den_neg_q <= den3_q[pc_pkg::DenW-1];
          den_q     <= den3_q[pc_pkg::DenW-1] ? pc_pkg::DenW'(-den3_q)
                                              : pc_pkg::DenW'(den3_q);
          axis_q    <= 1'b0;
          state_q   <= StDivLoad;
        end
        StDivLoad: begin
          quo_q     <= mom_sel[pc_pkg::MomW-1] ? pc_pkg::MomW'(-mom_sel)
                                               : pc_pkg::MomW'(mom_sel);
          quo_neg_q <= mom_sel[pc_pkg::MomW-1] ^ den_neg_q;
          rem_q     <= '0;
          div_cnt_q <= '0;
          state_q   <= StDiv;
        end
        StDiv: begin
          rem_q     <= div_ge ? div_diff[pc_pkg::DenW-1:0] : div_shift[pc_pkg::DenW-1:0];
          quo_q     <= {quo_q[pc_pkg::MomW-2:0], div_ge};
          div_cnt_q <= div_cnt_q + 1'b1;
          if (div_cnt_q == pc_pkg::DivCntW'(pc_pkg::MomW - 1)) begin
            state_q <= StDivSat;
          end
        end
        StDivSat: begin
          if (!axis_q) begin
            cx_q    <= sat_res;
            axis_q  <= 1'b1;
            state_q <= StDivLoad;
          end else begin
            state_q <= StOut;
          end
        end
        StOut: begin
          // Load the result once the output register is free, then clear the polygon.
          if (load_out) begin
            res_q.overflow   <= ovf_q;
            res_q.degenerate <= !ovf_q && (area_q == '0);
            res_q.centroid_x <= (ovf_q || area_q == '0) ? '0 : cx_q;
            res_q.centroid_y <= (ovf_q || area_q == '0) ? '0 : sat_res;
            first_x_q        <= '0;
            first_y_q        <= '0;
            prev_x_q         <= '0;
            prev_y_q         <= '0;
            area_q           <= '0;
            mom_x_q          <= '0;
            mom_y_q          <= '0;
            count_q          <= '0;
            ovf_q            <= 1'b0;
            closing_q        <= 1'b0;
            state_q          <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  // A result never flags both zero area and vertex overflow.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both degenerate and overflow");

  // A flagged result carries a zero centroid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser[0] || m_axis_tuser[1])) |-> (m_axis_tdata == '0))
    else $error("flagged result with nonzero centroid");

  // The kept vertex count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MAX_VERTICES))
    else $error("vertex count beyond limit");

  // The final vertex of a polygon always leads to a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && s_axis_tlast) |=> !s_axis_tready)
    else $error("input taken right after the final vertex");

endmodule

### tb/polygon_centroid_tb.sv
// Self-checking testbench for the streaming polygon centroid block.
module polygon_centroid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxVertices = 1024;
  localparam int unsigned DrainCycles = 400;

  // Shapes of the random polygons.
  typedef enum int {
    PolyRect,
    PolyBox,
    PolyWide,
    PolyCorner,
    PolyLine
  } poly_kind_e;

  typedef struct {
    logic [pc_pkg::CoordW-1:0] x;
    logic [pc_pkg::CoordW-1:0] y;
    logic                      last;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  vertex_t         pending_vertices[$];
  pc_pkg::result_t centroid_expected[$];
  int unsigned     mismatch_count = 0;
  int unsigned     vertices_queued = 0;
  logic            vtx_taken = 1'b0;

  // Shadow copy of the polygon accumulators.
  longint      ring_first_x, ring_first_y, ring_prev_x, ring_prev_y;
  longint      area2_acc, mom_x_acc, mom_y_acc;
  int unsigned ring_count = 0;
  bit          ring_overflow = 1'b0;

  // Sender and receiver pacing.
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_mode_left = 0;

  polygon_centroid #(
    .MAX_VERTICES(MaxVertices)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),   // vertex_x[15:0], vertex_y[31:16]
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),   // centroid_x[15:0], centroid_y[31:16]
    .m_axis_tuser (m_axis_tuser)    // degenerate[0], overflow[1]
  );

  // Clock and a single reset pulse at the start.
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // Clears the shadow polygon state.
  function automatic void clear_ring();
    ring_first_x = 0;
    ring_first_y = 0;
    ring_prev_x = 0;
    ring_prev_y = 0;
    area2_acc = 0;
    mom_x_acc = 0;
    mom_y_acc = 0;
    ring_count = 0;
    ring_overflow = 1'b0;
  endfunction

  // Adds one edge to the doubled area and the two first moments.
  function automatic void add_edge(longint px, longint py, longint qx, longint qy);
    longint cross_prod;
    cross_prod = px * qy - qx * py;
    area2_acc += cross_prod;
    mom_x_acc += (px + qx) * cross_prod;
    mom_y_acc += (py + qy) * cross_prod;
  endfunction

  function automatic logic [pc_pkg::CoordW-1:0] clamp_coord(longint q);
    if (q > 32767) return pc_pkg::CoordMax;
    if (q < -32768) return pc_pkg::CoordMin;
    return q[pc_pkg::CoordW-1:0];
  endfunction

  // Folds one accepted vertex into the shadow state; the last one yields a centroid.
  function automatic void accumulate_vertex(logic signed [pc_pkg::CoordW-1:0] vx,
                                            logic signed [pc_pkg::CoordW-1:0] vy,
                                            logic last);
    longint          x;
    longint          y;
    longint          denom;
    pc_pkg::result_t res;
    x = vx;
    y = vy;
    if (ring_count >= MaxVertices) begin
      ring_overflow = 1'b1;
    end else begin
      if (ring_count == 0) begin
        ring_first_x = x;
        ring_first_y = y;
      end else begin
        add_edge(ring_prev_x, ring_prev_y, x, y);
      end
      ring_prev_x = x;
      ring_prev_y = y;
      ring_count++;
    end
    if (last) begin
      add_edge(ring_prev_x, ring_prev_y, ring_first_x, ring_first_y);
      res = '0;
      res.overflow = ring_overflow;
      if (!ring_overflow) begin
        if (area2_acc == 0) begin
          res.degenerate = 1'b1;
        end else begin
          denom = 3 * area2_acc;
          res.centroid_x = clamp_coord(mom_x_acc / denom);
          res.centroid_y = clamp_coord(mom_y_acc / denom);
        end
      end
      centroid_expected.push_back(res);
      clear_ring();
    end
  endfunction

  // Sender: inputs change on the falling edge, in bursts with random gaps.
  always @(negedge clk_i) begin
    vertex_t v;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!(s_axis_tvalid && !vtx_taken)) begin
      if (gap_left > 0 || pending_vertices.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        v = pending_vertices.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {v.y, v.x};
        s_axis_tlast <= v.last;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14);
        end
      end
    end
  end

  // Receiver: switches between always ready, random and mostly stalled.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_mode_left = $urandom_range(5, 80);
      end else begin
        stall_mode_left--;
      end
      case (stall_mode)
        0: begin
          m_axis_tready <= 1'b1;
        end
        1: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          m_axis_tready <= ($urandom_range(0, 7) == 0);
        end
      endcase
    end
  end

  // Monitor: samples both transactions on the rising edge and checks results.
  always @(posedge clk_i) begin
    pc_pkg::result_t got;
    pc_pkg::result_t want;
    if (rst_ni) begin
      vtx_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        accumulate_vertex(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.centroid_x = m_axis_tdata[15:0];
        got.centroid_y = m_axis_tdata[31:16];
        got.degenerate = m_axis_tuser[0];
        got.overflow = m_axis_tuser[1];
        if (centroid_expected.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result x=%0d y=%0d degenerate=%0b overflow=%0b",
                   $realtime, $signed(got.centroid_x), $signed(got.centroid_y),
                   got.degenerate, got.overflow);
        end else begin
          want = centroid_expected.pop_front();
          if (got.centroid_x !== want.centroid_x) begin
            mismatch_count++;
            $display("%0t: centroid_x expected %0d, actual %0d", $realtime,
                     $signed(want.centroid_x), $signed(got.centroid_x));
          end
          if (got.centroid_y !== want.centroid_y) begin
            mismatch_count++;
            $display("%0t: centroid_y expected %0d, actual %0d", $realtime,
                     $signed(want.centroid_y), $signed(got.centroid_y));
          end
          if (got.degenerate !== want.degenerate) begin
            mismatch_count++;
            $display("%0t: degenerate expected %0b, actual %0b", $realtime,
                     want.degenerate, got.degenerate);
          end
          if (got.overflow !== want.overflow) begin
            mismatch_count++;
            $display("%0t: overflow expected %0b, actual %0b", $realtime,
                     want.overflow, got.overflow);
          end
        end
      end
    end
  end

  task automatic push_vertex(int x, int y, bit last);
    vertex_t v;
    v.x = x[pc_pkg::CoordW-1:0];
    v.y = y[pc_pkg::CoordW-1:0];
    v.last = last;
    pending_vertices.push_back(v);
    vertices_queued++;
  endtask

  function automatic int wide_coord();
    return $signed($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int corner_coord();
    case ($urandom_range(0, 6))
      0: return -32768;
      1: return -32767;
      2: return -1;
      3: return 0;
      4: return 1;
      5: return 32766;
      default: return 32767;
    endcase
  endfunction

  // Queues one random polygon of a random shape.
  task automatic push_random_polygon();
    poly_kind_e  kind;
    int unsigned n;
    int          cx, cy, r, dx, dy, x0, x1, y0, y1, tmp;
    kind = poly_kind_e'($urandom_range(0, 4));
    case ($urandom_range(0, 19))
      0, 1: n = $urandom_range(1, 2);
      2, 3, 4: n = $urandom_range(7, 16);
      5: n = $urandom_range(17, 60);
      default: n = $urandom_range(3, 6);
    endcase
    if (kind == PolyRect) begin
      x0 = wide_coord();
      x1 = wide_coord();
      y0 = wide_coord();
      y1 = wide_coord();
      if (x0 > x1) begin
        tmp = x0;
        x0 = x1;
        x1 = tmp;
      end
      if (y0 > y1) begin
        tmp = y0;
        y0 = y1;
        y1 = tmp;
      end
      // Either winding direction.
      if ($urandom_range(0, 1)) begin
        push_vertex(x0, y0, 0);
        push_vertex(x1, y0, 0);
        push_vertex(x1, y1, 0);
        push_vertex(x0, y1, 1);
      end else begin
        push_vertex(x0, y0, 0);
        push_vertex(x0, y1, 0);
        push_vertex(x1, y1, 0);
        push_vertex(x1, y0, 1);
      end
    end else begin
      cx = wide_coord();
      cy = wide_coord();
      r = 1 << $urandom_range(1, 12);
      dx = $signed($urandom_range(0, 40)) - 20;
      dy = $signed($urandom_range(0, 40)) - 20;
      for (int unsigned i = 0; i < n; i++) begin
        case (kind)
          PolyBox: begin
            push_vertex(cx + $signed($urandom_range(0, 2 * r)) - r,
                        cy + $signed($urandom_range(0, 2 * r)) - r, i == n - 1);
          end
          PolyWide: push_vertex(wide_coord(), wide_coord(), i == n - 1);
          PolyCorner: push_vertex(corner_coord(), corner_coord(), i == n - 1);
          default: begin
            // Points on one line, so the enclosed area is zero.
            tmp = $urandom_range(0, 60);
            push_vertex((cx >>> 4) + tmp * dx, (cy >>> 4) + tmp * dy, i == n - 1);
          end
        endcase
      end
    end
  endtask

  // Returns once every queued vertex is taken and every result has arrived.
  task automatic wait_for_idle();
    do begin
      @(posedge clk_i);
    end while (pending_vertices.size() != 0 || s_axis_tvalid ||
               centroid_expected.size() != 0);
  endtask

  // Stimulus sequence.
  initial begin
    clear_ring();

    // Single vertex and two vertices: zero area.
    push_vertex(32767, -32768, 1);
    push_vertex(-32768, 32767, 0);
    push_vertex(32767, -32768, 1);
    // Counterclockwise and clockwise triangles.
    push_vertex(0, 0, 0);
    push_vertex(30, 0, 0);
    push_vertex(0, 30, 1);
    push_vertex(-300, -600, 0);
    push_vertex(-300, 900, 0);
    push_vertex(1200, -600, 1);
    // Square spanning the full coordinate range.
    push_vertex(-32768, -32768, 0);
    push_vertex(32767, -32768, 0);
    push_vertex(32767, 32767, 0);
    push_vertex(-32768, 32767, 1);
    // Collinear triangle.
    push_vertex(-100, -100, 0);
    push_vertex(0, 0, 0);
    push_vertex(100, 100, 1);
    // Balanced bowtie with extreme coordinates: the lobes cancel to zero net area, so the result is degenerate.
    push_vertex(-32768, -32768, 0);
    push_vertex(32767, 32767, 0);
    push_vertex(32767, -32768, 0);
    push_vertex(-32767, 32767, 1);
    wait_for_idle();

    // One polygon past the vertex limit; the last three are dropped.
    for (int unsigned i = 0; i < MaxVertices + 3; i++) begin
      push_vertex(wide_coord(), wide_coord(), i == MaxVertices + 2);
    end
    wait_for_idle();

    // Random polygons in two halves, with a full drain in between.
    vertices_queued = 0;
    while (vertices_queued < 400) push_random_polygon();
    wait_for_idle();
    vertices_queued = 0;
    while (vertices_queued < 400) push_random_polygon();
    wait_for_idle();

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
